FILE: hdl/telnet_receive_deframer_assert.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TELNET_RECEIVE_DEFRAMER_ASSERT_SVH
`define TELNET_RECEIVE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/trd_pkg.sv
package trd_pkg;

	// Parser states.
	typedef enum logic [2:0] {
		ST_DATA = 3'd0,
		ST_CR   = 3'd1,
		ST_IAC  = 3'd2,
		ST_SB   = 3'd3,
		ST_SE   = 3'd4,
		ST_VOID = 3'd5,
		ST_KILL = 3'd6
	} parse_state_t;

	// Decoded meaning of the byte that follows IAC.
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_AYT,
		CMD_AO,
		CMD_DM,
		CMD_START3,
		CMD_START,
		CMD_CLIENT,
		CMD_KILL,
		CMD_SB,
		CMD_NEG,
		CMD_IAC,
		CMD_BLOCK
	} cmd_t;

	// Event codes on the result channel.
	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_AYT    = 3'd1,
		EV_AO     = 3'd2,
		EV_CLIENT = 3'd3,
		EV_KILL   = 3'd4,
		EV_START3 = 3'd5
	} event_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_CLIENT_AT_RESET = 3'd0,
		REG_INITIAL_ROWS    = 3'd1,
		REG_CODE_START3     = 3'd2,
		REG_CODE_START      = 3'd3,
		REG_CODE_CLIENT     = 3'd4,
		REG_CODE_POST_KILL  = 3'd5,
		REG_CODE_BLOCK      = 3'd6
	} reg_index_t;

	localparam logic [7:0] T_SE   = 8'd240;
	localparam logic [7:0] T_DM   = 8'd242;
	localparam logic [7:0] T_AO   = 8'd245;
	localparam logic [7:0] T_AYT  = 8'd246;
	localparam logic [7:0] T_SB   = 8'd250;
	localparam logic [7:0] T_WILL = 8'd251;
	localparam logic [7:0] T_WONT = 8'd252;
	localparam logic [7:0] T_DO   = 8'd253;
	localparam logic [7:0] T_DONT = 8'd254;
	localparam logic [7:0] T_IAC  = 8'd255;

	localparam logic [7:0] OPT_NAWS = 8'd31;
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [6:0] CH_DEL   = 7'h7f;

	localparam logic [7:0] ROWS_DEFAULT = 8'd24;
	localparam logic [7:0] ROWS_MIN     = 8'd5;
	localparam logic [7:0] ROWS_MAX     = 8'd100;

	// A NAWS body is option, width hi/lo, height hi/lo: height low sits at index 4.
	localparam int NAWS_LEN        = 5;
	localparam int NAWS_HEIGHT_IDX = 4;

	localparam logic [7:0] RST_CODE_START3    = 8'd1;
	localparam logic [7:0] RST_CODE_START     = 8'd2;
	localparam logic [7:0] RST_CODE_CLIENT    = 8'd3;
	localparam logic [7:0] RST_CODE_POST_KILL = 8'd4;
	localparam logic [7:0] RST_CODE_BLOCK     = 8'd5;

	typedef struct packed {
		logic [7:0] start3;
		logic [7:0] start;
		logic [7:0] client;
		logic [7:0] post_kill;
		logic [7:0] block;
	} cmd_codes_t;

	// Reload requests from the configuration port into the parser.
	typedef struct packed {
		logic       ld_flags;
		logic       flags_val;
		logic       ld_rows;
		logic [7:0] rows_val;
	} reload_t;

	typedef struct packed {
		logic       char_valid;
		logic [6:0] char_out;
		event_t     event_res;
		logic [7:0] rows_now;
		logic       client_now;
		logic       block_now;
		logic       byte_now;
	} result_t;

	// Command decode after IAC; the order of the tests sets the priority.
	function automatic cmd_t decode_cmd(input logic [7:0] c, input cmd_codes_t codes);
		cmd_t cmd;
		if (c == T_AYT)
			cmd = CMD_AYT;
		else if (c == T_AO)
			cmd = CMD_AO;
		else if (c == T_DM)
			cmd = CMD_DM;
		else if (c == codes.start3)
			cmd = CMD_START3;
		else if (c == codes.start)
			cmd = CMD_START;
		else if (c == codes.client)
			cmd = CMD_CLIENT;
		else if (c == codes.post_kill)
			cmd = CMD_KILL;
		else if (c == T_SB)
			cmd = CMD_SB;
		else if (c == T_WILL || c == T_WONT || c == T_DO || c == T_DONT)
			cmd = CMD_NEG;
		else if (c == T_IAC)
			cmd = CMD_IAC;
		else if (c == codes.block)
			cmd = CMD_BLOCK;
		else
			cmd = CMD_NONE;
		return cmd;
	endfunction

endpackage

FILE: hdl/trd_in_if.sv
interface trd_in_if;
	logic               valid;
	logic               ready;
	logic [7:0]         rx_byte;
	logic signed [15:0] post_count;

	modport source(output valid, rx_byte, post_count, input ready);
	modport sink(input valid, rx_byte, post_count, output ready);
endinterface

FILE: hdl/trd_out_if.sv
interface trd_out_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [6:0] char_out;
	logic [2:0] event_res;
	logic [7:0] rows_now;
	logic       client_now;
	logic       block_now;
	logic       byte_now;

	modport source(output valid, char_valid, char_out, event_res, rows_now, client_now,
		block_now, byte_now, input ready);
	modport sink(input valid, char_valid, char_out, event_res, rows_now, client_now,
		block_now, byte_now, output ready);
endinterface

FILE: hdl/trd_parser.sv
module trd_parser
	import trd_pkg::*;
#(
	parameter int SUB_KEEP = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         c,
	input  logic signed [15:0] pc,
	input  cmd_codes_t         codes,
	input  reload_t            reload,
	output result_t            res
);

	localparam int CNT_W = $clog2(SUB_KEEP + 1);
	localparam int IDX_W = $clog2(SUB_KEEP);

	parse_state_t     state_q, state_n;
	logic             client_q, client_n;
	logic             block_q, block_n;
	logic             byte_q, byte_n;
	logic [7:0]       rows_q, rows_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [7:0]       sub_q [SUB_KEEP];

	cmd_t       cmd;
	logic       push, do_cmd, do_dat, finish, kill_hit;
	logic [7:0] naws_rows, fin_rows;
	logic       valid;
	logic [6:0] ch;
	event_t     ev;

	assign cmd      = decode_cmd(c, codes);
	assign kill_hit = (pc > 16'sd0) && (c == pc[7:0]);

	// Rows at the end of a body: NAWS height, then the sanity fallback.
	always_comb begin
		naws_rows = rows_q;
		if (cnt_q != '0 && sub_q[0] == OPT_NAWS) begin
			naws_rows = (cnt_q >= CNT_W'(NAWS_LEN)) ? sub_q[IDX_W'(NAWS_HEIGHT_IDX)] : 8'd0;
		end
		fin_rows = (naws_rows < ROWS_MIN || naws_rows > ROWS_MAX) ? ROWS_DEFAULT : naws_rows;
	end

	// Next parser state.
	always_comb begin
		unique case (state_q)
			ST_CR: begin
				if (c == CH_NUL || c == CH_LF)
					state_n = ST_DATA;
				else if (c == T_IAC)
					state_n = ST_IAC;
				else if (c == CH_CR && !client_q)
					state_n = ST_CR;
				else
					state_n = ST_DATA;
			end
			ST_IAC, ST_SE: begin
				if (state_q == ST_SE && c == T_SE)
					state_n = ST_DATA;
				else if (state_q == ST_SE && c == T_IAC)
					state_n = ST_SB;
				else if (cmd == CMD_KILL)
					state_n = ST_KILL;
				else if (cmd == CMD_SB)
					state_n = ST_SB;
				else if (cmd == CMD_NEG)
					state_n = ST_VOID;
				else
					state_n = ST_DATA;
			end
			ST_SB:   state_n = (c == T_IAC) ? ST_SE : ST_SB;
			ST_VOID: state_n = ST_DATA;
			ST_KILL: state_n = ST_DATA;
			default: begin
				if (c == T_IAC)
					state_n = ST_IAC;
				else if (c == CH_CR && !client_q)
					state_n = ST_CR;
				else
					state_n = ST_DATA;
			end
		endcase
	end

	// Outputs and datapath state.
	always_comb begin
		push     = 1'b0;
		do_cmd   = 1'b0;
		do_dat   = 1'b0;
		finish   = 1'b0;
		valid    = 1'b0;
		ch       = '0;
		ev       = EV_NONE;
		client_n = client_q;
		block_n  = block_q;
		byte_n   = byte_q;
		rows_n   = rows_q;
		cnt_n    = cnt_q;
		unique case (state_q)
			ST_CR:   do_dat = (c != CH_NUL && c != CH_LF);
			ST_IAC:  do_cmd = 1'b1;
			ST_SB:   push = (c != T_IAC);
			ST_SE: begin
				if (c == T_SE) begin
					finish = 1'b1;
				end else if (c == T_IAC) begin
					push = 1'b1;
				end else begin
					finish = 1'b1;
					do_cmd = 1'b1;
				end
			end
			ST_KILL: ev = kill_hit ? EV_KILL : EV_NONE;
			ST_VOID: ev = EV_NONE;
			default: do_dat = 1'b1;
		endcase
		if (finish)
			rows_n = fin_rows;
		if (push && cnt_q < CNT_W'(SUB_KEEP))
			cnt_n = cnt_q + CNT_W'(1);
		if (do_dat && c != T_IAC) begin
			valid = 1'b1;
			ch    = c[6:0];
		end
		if (do_cmd) begin
			unique case (cmd)
				CMD_AYT: ev = EV_AYT;
				CMD_AO:  ev = EV_AO;
				CMD_START3: begin
					client_n = 1'b1;
					block_n  = 1'b0;
					byte_n   = 1'b1;
					ev       = EV_START3;
				end
				CMD_START: begin
					block_n = 1'b0;
					byte_n  = 1'b1;
				end
				CMD_CLIENT: ev = EV_CLIENT;
				CMD_SB:     cnt_n = '0;
				CMD_IAC: begin
					valid = 1'b1;
					ch    = CH_DEL;
				end
				CMD_BLOCK: block_n = 1'b0;
				default:   ev = EV_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_DATA;
			client_q <= 1'b0;
			block_q  <= 1'b0;
			byte_q   <= 1'b0;
			rows_q   <= ROWS_DEFAULT;
			cnt_q    <= '0;
		end else begin
			if (step) begin
				state_q <= state_n;
				cnt_q   <= cnt_n;
			end
			if (reload.ld_flags) begin
				client_q <= reload.flags_val;
				block_q  <= reload.flags_val;
				byte_q   <= reload.flags_val;
			end else if (step) begin
				client_q <= client_n;
				block_q  <= block_n;
				byte_q   <= byte_n;
			end
			if (reload.ld_rows)
				rows_q <= (reload.rows_val == 8'd0) ? ROWS_DEFAULT : reload.rows_val;
			else if (step)
				rows_q <= rows_n;
		end
	end

	// Body capture; entries are only read after being written in the current body.
	always_ff @(posedge clk) begin
		if (step && push && cnt_q < CNT_W'(SUB_KEEP))
			sub_q[cnt_q[IDX_W-1:0]] <= c;
	end

	assign res = '{
		char_valid: valid,
		char_out:   ch,
		event_res:  ev,
		rows_now:   rows_n,
		client_now: client_n,
		block_now:  block_n,
		byte_now:   byte_n
	};

endmodule

FILE: hdl/telnet_receive_deframer.sv
// Telnet receive deframer.
// Bytes from the link arrive one per beat on din (rx_byte plus the current signed
// post_count). Every accepted beat yields exactly one result beat on dout: an optional
// 7-bit character, an event code, and the screen rows and mode flags as they stand
// after that byte.
// The parser state is updated in the cycle a beat is accepted and the result is held
// in a single output register, so the result appears in the cycle after acceptance and one
// byte is taken per cycle while results are drained. That register is the only buffering:
// din.ready is high whenever it is empty or being drained, so a stalled receiver holds the
// current result and stops intake until the beat is taken.
// Configuration writes through wr_en/wr_index/wr_data are taken at once and are meant
// for idle periods; writing client_at_reset reloads the mode flags and writing
// initial_rows reloads the screen rows (zero means 24).
// Asynchronous reset returns the parser to plain data, the registers to their defaults,
// the flags to zero and the rows to 24; no result is pending afterwards.
`include "telnet_receive_deframer_assert.svh"

module telnet_receive_deframer
	import trd_pkg::*;
#(
	parameter int SUB_KEEP = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data,
	trd_in_if.sink     din,
	trd_out_if.source  dout
);

	// Configuration registers.
	cmd_codes_t codes_q;
	reload_t    reload;

	// Output stage.
	logic    out_valid_q;
	result_t res_q;
	result_t res_d;
	logic    step;

	// The ready signal only depends on the output register having room.
	assign din.ready = !out_valid_q || dout.ready;
	assign step      = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q           <= '{
				start3:    RST_CODE_START3,
				start:     RST_CODE_START,
				client:    RST_CODE_CLIENT,
				post_kill: RST_CODE_POST_KILL,
				block:     RST_CODE_BLOCK
			};
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CODE_START3:     codes_q.start3    <= wr_data;
				REG_CODE_START:      codes_q.start     <= wr_data;
				REG_CODE_CLIENT:     codes_q.client    <= wr_data;
				REG_CODE_POST_KILL:  codes_q.post_kill <= wr_data;
				REG_CODE_BLOCK:      codes_q.block     <= wr_data;
				default:             codes_q           <= codes_q;
			endcase
		end
	end

	// A write to either of the first two registers acts only by reloading the
	// live state that it seeds; nothing else reads those values.
	assign reload = '{
		ld_flags:  wr_en && (wr_index == REG_CLIENT_AT_RESET),
		flags_val: wr_data[0],
		ld_rows:   wr_en && (wr_index == REG_INITIAL_ROWS),
		rows_val:  wr_data
	};

	trd_parser #(
		.SUB_KEEP(SUB_KEEP)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.c      (din.rx_byte),
		.pc     (din.post_count),
		.codes  (codes_q),
		.reload (reload),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res_d;
	end

	assign dout.valid      = out_valid_q;
	assign dout.char_valid = res_q.char_valid;
	assign dout.char_out   = res_q.char_out;
	assign dout.event_res  = res_q.event_res;
	assign dout.rows_now   = res_q.rows_now;
	assign dout.client_now = res_q.client_now;
	assign dout.block_now  = res_q.block_now;
	assign dout.byte_now   = res_q.byte_now;

	// Every accepted byte must leave a result beat behind it.
	`TRD_ASSERT_NEXT(a_step_gives_result, step, dout.valid, "accepted byte produced no result")
	// A held result must block further intake.
	`TRD_ASSERT_NOW(a_stall_blocks_input, dout.valid && !dout.ready, !din.ready,
		"input taken while result stalled")
	// A character and an event never come from the same byte.
	`TRD_ASSERT_NOW(a_char_xor_event, dout.valid && dout.char_valid, dout.event_res == EV_NONE,
		"character and event in one result")
	// Configuration and the 24 fallback: rows never read zero.
	`TRD_ASSERT_NOW(a_rows_nonzero, dout.valid, dout.rows_now != 8'd0,
		"screen rows reported as zero")

endmodule
